// ===== design/pn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pn_pkg;

    // fixed-point setup
    localparam int ANGLE_BITS      = 10;
    localparam int COORD_FRAC_BITS = 16;
    localparam int QTR_BITS        = ANGLE_BITS - 2;
    localparam int QTR_SIZE        = 1 << QTR_BITS;
    localparam int T_SHIFT         = 18 - ANGLE_BITS;
    localparam int SINE_W          = 17;
    localparam int GRAD_W          = SINE_W + 1;
    localparam int OFS_W           = 17;
    localparam int DOT_W           = OFS_W + GRAD_W + 1;

    // hash multipliers
    localparam logic [31:0] HASH_K1 = 32'd3284157443;
    localparam logic [31:0] HASH_K2 = 32'd1911520717;
    localparam logic [31:0] HASH_K3 = 32'd2048419325;

    typedef logic signed [DOT_W-1:0] t_dot;
    typedef logic signed [GRAD_W-1:0] t_grad;
    typedef logic signed [OFS_W-1:0] t_ofs;

    // gradient quadrant of the angle
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    // polynomial quarter sine, q16 in and out
    function automatic logic [SINE_W-1:0] quarter_sine(input longint unsigned t);
        longint unsigned t2;
        longint unsigned inner;
        longint unsigned p;
        longint unsigned s;
        t2    = (t * t) >> 16;
        inner = 64'd42155 - ((t2 * 64'd4765) >> 16);
        p     = 64'd102939 - ((t2 * inner) >> 16);
        s     = (t * p) >> 16;
        if (s > 64'd65536) begin
            s = 64'd65536;
        end
        return SINE_W'(s);
    endfunction

    // one entry per quadrant step, both ends included
    function automatic logic [(QTR_SIZE+1)*SINE_W-1:0] build_sine();
        logic [(QTR_SIZE+1)*SINE_W-1:0] tbl;
        tbl = '0;
        for (int i = 0; i <= QTR_SIZE; i++) begin
            tbl[i*SINE_W +: SINE_W] = quarter_sine(64'(i) << T_SHIFT);
        end
        return tbl;
    endfunction

    localparam logic [(QTR_SIZE+1)*SINE_W-1:0] SINE_TBL = build_sine();

    function automatic logic [SINE_W-1:0] sine_at(input logic [QTR_BITS:0] i);
        return SINE_TBL[i*SINE_W +: SINE_W];
    endfunction

endpackage
`default_nettype wire

// ===== design/pn_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pn_hash (
    input  wire logic        i_clk,
    input  wire logic [2:0]  i_en,
    input  wire logic [31:0] i_cx,
    input  wire logic [31:0] i_cy,
    output logic [31:0]      o_hash
);
    import pn_pkg::*;

    logic [31:0] r_a1;
    logic [31:0] r_cy1;
    logic [31:0] r_a2;
    logic [31:0] r_b;
    logic [31:0] r_h;
    logic [31:0] n_b;
    logic [31:0] n_h;

    // mix steps, one multiply per stage
    always_comb begin
        n_b = 32'((r_cy1 ^ {r_a1[15:0], r_a1[31:16]}) * HASH_K2);
        n_h = 32'((r_a2 ^ {r_b[15:0], r_b[31:16]}) * HASH_K3);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a1  <= 32'(i_cx * HASH_K1);
            r_cy1 <= i_cy;
        end
        if (i_en[1]) begin
            r_b  <= n_b;
            r_a2 <= r_a1;
        end
        if (i_en[2]) begin
            r_h <= n_h;
        end
    end

    assign o_hash = r_h;
endmodule
`default_nettype wire

// ===== design/pn_fade.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pn_fade (
    input  wire logic        i_clk,
    input  wire logic [2:0]  i_en,
    input  wire logic [15:0] i_u,
    output logic [16:0]      o_w
);
    import pn_pkg::*;

    logic [31:0] r_u2;
    logic [15:0] r_u1;
    logic [15:0] r_t3;
    logic [35:0] r_p;
    logic [16:0] r_w;
    logic [47:0] cube;
    logic [37:0] n_p;
    logic [51:0] prod;
    logic [19:0] w_raw;

    // t^3 and the quadratic factor, then their product
    always_comb begin
        cube  = 48'(r_u2) * 48'(r_u1);
        n_p   = 38'(r_u2) * 38'd6 + (38'd10 << 32) - ((38'(r_u1) * 38'd15) << 16);
        prod  = 52'(r_t3) * 52'(r_p);
        w_raw = prod[51:32];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_u2 <= 32'(i_u) * 32'(i_u);
            r_u1 <= i_u;
        end
        if (i_en[1]) begin
            r_t3 <= cube[47:32];
            r_p  <= n_p[35:0];
        end
        if (i_en[2]) begin
            r_w <= (w_raw > 20'd65536) ? 17'd65536 : w_raw[16:0];
        end
    end

    assign o_w = r_w;
endmodule
`default_nettype wire

// ===== design/pn_grad.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pn_grad (
    input  wire logic           i_clk,
    input  wire logic [1:0]     i_en,
    input  wire logic [31:0]    i_hash,
    input  wire pn_pkg::t_ofs   i_dx,
    input  wire pn_pkg::t_ofs   i_dy,
    output pn_pkg::t_dot        o_dot
);
    import pn_pkg::*;

    logic [ANGLE_BITS-1:0] idx;
    t_quad                 quad;
    logic [QTR_BITS-1:0]   pos;
    t_grad                 s_val;
    t_grad                 c_val;
    t_grad                 n_gx;
    t_grad                 n_gy;
    t_grad                 r_gx;
    t_grad                 r_gy;
    t_ofs                  r_dx;
    t_ofs                  r_dy;
    t_dot                  r_dot;
    logic signed [DOT_W-2:0] px;
    logic signed [DOT_W-2:0] py;

    // angle lookup and quadrant rotation
    always_comb begin
        idx   = i_hash[31 -: ANGLE_BITS];
        quad  = t_quad'(idx[ANGLE_BITS-1 -: 2]);
        pos   = idx[QTR_BITS-1:0];
        s_val = $signed({1'b0, sine_at({1'b0, pos})});
        c_val = $signed({1'b0, sine_at((QTR_BITS+1)'(QTR_SIZE) - {1'b0, pos})});
        case (quad)
            QUAD_0: begin
                n_gx = c_val;
                n_gy = s_val;
            end
            QUAD_1: begin
                n_gx = -s_val;
                n_gy = c_val;
            end
            QUAD_2: begin
                n_gx = -c_val;
                n_gy = -s_val;
            end
            default: begin
                n_gx = s_val;
                n_gy = -c_val;
            end
        endcase
    end

    // dot with the corner offset
    always_comb begin
        px = r_dx * r_gx;
        py = r_dy * r_gy;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_gx <= n_gx;
            r_gy <= n_gy;
            r_dx <= i_dx;
            r_dy <= i_dy;
        end
        if (i_en[1]) begin
            r_dot <= {px[DOT_W-2], px} + {py[DOT_W-2], py};
        end
    end

    assign o_dot = r_dot;
endmodule
`default_nettype wire

// ===== design/perlin_noise_2d.sv =====
`timescale 1ns / 1ps
`default_nettype none
// 2d perlin gradient noise: each word on the input carries one point (x, y) in
// signed fixed point and gives one noise word in signed q1.15. The block is a
// ten-stage pipeline and takes one point per cycle unless a stall has filled it; a
// result word passes through the split stage, the three chained hash multiplies,
// the gradient lookup, the dot product and two stages for each of the two blends.
// Every stage holds its word while the stage after it is full and stalled, so a
// stall on the output fills the empty stages first and the input keeps taking
// points until the pipe is full.
module perlin_noise_2d (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [63:0] i_s_axis_tdata,  // x_coord, y_coord
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata   // noise_value
);
    import pn_pkg::*;

    localparam int STAGES = 10;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] en;

    logic [31:0] r_x0, r_x1, r_y0, r_y1;
    logic [15:0] r_ux [0:3];
    logic [15:0] r_uy [0:3];
    logic [16:0] wx_f, wy_f;
    logic [16:0] r_wx [4:5];
    logic [16:0] r_wy [4:7];
    logic [31:0] h00, h10, h01, h11;
    t_dot        n00, n10, n01, n11;
    t_dot        r_a_lo, r_a_hi, r_lo, r_hi, r_lo8;
    logic signed [54:0] r_p_lo, r_p_hi, r_ph;
    logic signed [54:0] p_lo, p_hi, p_v;
    logic signed [36:0] d_lo, d_hi, d_v;
    t_dot        v_sum;
    logic signed [18:0] v_sh;
    logic [15:0] r_out;
    logic signed [31:0] x_in, y_in;
    logic [47:0] x_wide, y_wide;

    // stage advance: a stage moves when empty or when the next one moves
    always_comb begin
        en[STAGES-1] = !r_vld[STAGES-1] || i_m_axis_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // split into lattice cell and q0.16 fraction
    always_comb begin
        x_in   = $signed(i_s_axis_tdata[31:0]);
        y_in   = $signed(i_s_axis_tdata[63:32]);
        x_wide = {i_s_axis_tdata[31:0], 16'b0};
        y_wide = {i_s_axis_tdata[63:32], 16'b0};
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_x0    <= 32'(x_in >>> COORD_FRAC_BITS);
            r_x1    <= 32'(x_in >>> COORD_FRAC_BITS) + 32'd1;
            r_y0    <= 32'(y_in >>> COORD_FRAC_BITS);
            r_y1    <= 32'(y_in >>> COORD_FRAC_BITS) + 32'd1;
            r_ux[0] <= x_wide[COORD_FRAC_BITS +: 16];
            r_uy[0] <= y_wide[COORD_FRAC_BITS +: 16];
        end
        for (int k = 1; k <= 3; k++) begin
            if (en[k]) begin
                r_ux[k] <= r_ux[k-1];
                r_uy[k] <= r_uy[k-1];
            end
        end
    end

    // corner hashes, stages one to three
    pn_hash u_hash00 (.i_clk, .i_en(en[3:1]), .i_cx(r_x0), .i_cy(r_y0), .o_hash(h00));
    pn_hash u_hash10 (.i_clk, .i_en(en[3:1]), .i_cx(r_x1), .i_cy(r_y0), .o_hash(h10));
    pn_hash u_hash01 (.i_clk, .i_en(en[3:1]), .i_cx(r_x0), .i_cy(r_y1), .o_hash(h01));
    pn_hash u_hash11 (.i_clk, .i_en(en[3:1]), .i_cx(r_x1), .i_cy(r_y1), .o_hash(h11));

    // fade weights alongside the hashes
    pn_fade u_fade_x (.i_clk, .i_en(en[3:1]), .i_u(r_ux[0]), .o_w(wx_f));
    pn_fade u_fade_y (.i_clk, .i_en(en[3:1]), .i_u(r_uy[0]), .o_w(wy_f));

    // gradients and dots, stages four and five
    pn_grad u_grad00 (.i_clk, .i_en(en[5:4]), .i_hash(h00),
                      .i_dx($signed({1'b0, r_ux[3]})), .i_dy($signed({1'b0, r_uy[3]})),
                      .o_dot(n00));
    pn_grad u_grad10 (.i_clk, .i_en(en[5:4]), .i_hash(h10),
                      .i_dx($signed({1'b1, r_ux[3]})), .i_dy($signed({1'b0, r_uy[3]})),
                      .o_dot(n10));
    pn_grad u_grad01 (.i_clk, .i_en(en[5:4]), .i_hash(h01),
                      .i_dx($signed({1'b0, r_ux[3]})), .i_dy($signed({1'b1, r_uy[3]})),
                      .o_dot(n01));
    pn_grad u_grad11 (.i_clk, .i_en(en[5:4]), .i_hash(h11),
                      .i_dx($signed({1'b1, r_ux[3]})), .i_dy($signed({1'b1, r_uy[3]})),
                      .o_dot(n11));

    // blend arithmetic
    always_comb begin
        d_lo  = {n10[DOT_W-1], n10} - {n00[DOT_W-1], n00};
        d_hi  = {n11[DOT_W-1], n11} - {n01[DOT_W-1], n01};
        p_lo  = d_lo * $signed({1'b0, r_wx[5]});
        p_hi  = d_hi * $signed({1'b0, r_wx[5]});
        d_v   = {r_hi[DOT_W-1], r_hi} - {r_lo[DOT_W-1], r_lo};
        p_v   = d_v * $signed({1'b0, r_wy[7]});
        v_sum = r_lo8 + $signed(r_ph[51:16]);
        v_sh  = v_sum[DOT_W-1:17];
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_wx[4] <= wx_f;
            r_wy[4] <= wy_f;
        end
        if (en[5]) begin
            r_wx[5] <= r_wx[4];
            r_wy[5] <= r_wy[4];
        end
        if (en[6]) begin
            r_a_lo  <= n00;
            r_a_hi  <= n01;
            r_p_lo  <= p_lo;
            r_p_hi  <= p_hi;
            r_wy[6] <= r_wy[5];
        end
        if (en[7]) begin
            r_lo    <= r_a_lo + $signed(r_p_lo[51:16]);
            r_hi    <= r_a_hi + $signed(r_p_hi[51:16]);
            r_wy[7] <= r_wy[6];
        end
        if (en[8]) begin
            r_lo8 <= r_lo;
            r_ph  <= p_v;
        end
        // final scale and saturation
        if (en[9]) begin
            if (v_sh > 19'sd32767) begin
                r_out <= 16'h7fff;
            end else if (v_sh < -19'sd32768) begin
                r_out <= 16'h8000;
            end else begin
                r_out <= v_sh[15:0];
            end
        end
    end

    assign o_s_axis_tready = en[0];
    assign o_m_axis_tvalid = r_vld[STAGES-1];
    assign o_m_axis_tdata  = r_out;
endmodule
`default_nettype wire

// ===== design/pn_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pn_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic [63:0] i_s_axis_tdata,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [15:0] o_m_axis_tdata
);
    // pipe comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output word valid right after reset");

    // an empty output stage never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

    // a moving output lets every stage move
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tready |-> o_s_axis_tready)
        else $error("input stalled while output drains");

    // stalled result holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled output word changed");
endmodule

bind perlin_noise_2d pn_checker u_pn_checker (.*);
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import pn_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata;  // x_coord, y_coord
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [15:0] o_m_axis_tdata;  // noise_value

    perlin_noise_2d u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    localparam int LATENCY = 10;

    logic [63:0]       point_queue[$];
    logic signed [15:0] noise_expected[$];
    int  mismatch_count = 0;
    bit  sender_paused;
    bit  receiver_hold;
    bit  in_taken;
    int  hold_cycles;
    int  send_gap;
    int  recv_gap;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // floor division by a power of two
    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned qsine(input longint unsigned t);
        longint unsigned t2, inner, p, s;
        t2    = (t * t) >> 16;
        inner = 42155 - ((t2 * 4765) >> 16);
        p     = 102939 - ((t2 * inner) >> 16);
        s     = (t * p) >> 16;
        if (s > 65536) s = 65536;
        return s;
    endfunction

    function automatic logic [31:0] rot16(input logic [31:0] v);
        return {v[15:0], v[31:16]};
    endfunction

    // gradient at a lattice corner dotted with the offset
    function automatic longint corner_dot(input logic [31:0] cx, input logic [31:0] cy,
                                          input longint dx, input longint dy);
        logic [31:0] a, b;
        logic [ANGLE_BITS-1:0] idx;
        t_quad q;
        longint unsigned t;
        longint s, c, gx, gy;
        a = cx * HASH_K1;
        b = cy ^ rot16(a);
        b = b * HASH_K2;
        a = a ^ rot16(b);
        a = a * HASH_K3;
        idx = a[31 -: ANGLE_BITS];
        q = t_quad'(idx[ANGLE_BITS-1 -: 2]);
        t = longint'(idx[QTR_BITS-1:0]) << (18 - ANGLE_BITS);
        s = longint'(qsine(t));
        c = longint'(qsine(65536 - t));
        case (q)
            QUAD_0: begin gx = c;  gy = s;  end
            QUAD_1: begin gx = -s; gy = c;  end
            QUAD_2: begin gx = -c; gy = -s; end
            default: begin gx = s; gy = -c; end
        endcase
        return dx * gx + dy * gy;
    endfunction

    function automatic longint smoother(input longint unsigned u);
        longint unsigned u2, t3, p, w;
        u2 = u * u;
        t3 = (u2 * u) >> 32;
        p  = 6 * u2 + (longint'(10) << 32) - ((15 * u) << 16);
        w  = (t3 * p) >> 32;
        if (w > 65536) w = 65536;
        return longint'(w);
    endfunction

    function automatic longint lerp(input longint a, input longint b, input longint w);
        return a + floor_shr((b - a) * w, 16);
    endfunction

    function automatic logic signed [15:0] noise_at(input logic [63:0] pt);
        logic [31:0] xv, yv, x0, y0;
        longint ux, uy, wx, wy, n00, n10, n01, n11, lo, hi, v;
        xv = pt[31:0];
        yv = pt[63:32];
        x0 = 32'($signed(xv) >>> COORD_FRAC_BITS);
        y0 = 32'($signed(yv) >>> COORD_FRAC_BITS);
        ux = longint'(xv[COORD_FRAC_BITS-1:0]);
        uy = longint'(yv[COORD_FRAC_BITS-1:0]);
        if (COORD_FRAC_BITS > 16) begin
            ux = ux >> (COORD_FRAC_BITS - 16);
            uy = uy >> (COORD_FRAC_BITS - 16);
        end else begin
            ux = ux << (16 - COORD_FRAC_BITS);
            uy = uy << (16 - COORD_FRAC_BITS);
        end
        wx  = smoother(ux);
        wy  = smoother(uy);
        n00 = corner_dot(x0, y0, ux, uy);
        n10 = corner_dot(x0 + 1, y0, ux - 65536, uy);
        n01 = corner_dot(x0, y0 + 1, ux, uy - 65536);
        n11 = corner_dot(x0 + 1, y0 + 1, ux - 65536, uy - 65536);
        lo  = lerp(n00, n10, wx);
        hi  = lerp(n01, n11, wx);
        v   = floor_shr(lerp(lo, hi, wy), 17);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return {16'($urandom_range(0, 7) - 4), 16'h0000};
            1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            2: return {16'($urandom()), 16'h0} | 32'($urandom_range(0, 3));
            default: return $urandom();
        endcase
    endfunction

    // sender: one point per handshake, random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
            send_gap        <= 0;
        end else if (i_s_axis_tvalid && !in_taken) begin
            // hold the word until taken
        end else if (send_gap > 0 || sender_paused) begin
            i_s_axis_tvalid <= 1'b0;
            if (send_gap > 0) send_gap <= send_gap - 1;
        end else if (point_queue.size() > 0) begin
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata  <= point_queue.pop_front();
            send_gap        <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        end else begin
            i_s_axis_tvalid <= 1'b0;
        end
    end

    // record expectations on every accepted point
    always @(posedge i_clk) begin
        in_taken = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (in_taken)
            noise_expected.push_back(noise_at(i_s_axis_tdata));
    end

    // receiver ready with random stalls and a long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            recv_gap        <= 0;
        end else if (receiver_hold) begin
            i_m_axis_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            i_m_axis_tready <= 1'b0;
            recv_gap        <= recv_gap - 1;
        end else begin
            i_m_axis_tready <= 1'b1;
            if (o_m_axis_tvalid)
                recv_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
        end
    end

    // long receiver stall counted in its own process
    initial begin
        receiver_hold = 1'b0;
        wait (i_rst_n);
        repeat (300) @(posedge i_clk);
        receiver_hold = 1'b1;
        hold_cycles   = 0;
        while (hold_cycles < 200) begin
            @(posedge i_clk);
            hold_cycles++;
        end
        receiver_hold = 1'b0;
    end

    // compare each noise word with the oldest expectation
    always @(posedge i_clk) begin
        logic signed [15:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (noise_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected noise word %h", o_m_axis_tdata);
            end else begin
                want = noise_expected.pop_front();
                if (o_m_axis_tdata !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("noise mismatch: expected %0d actual %0d",
                                 want, $signed(o_m_axis_tdata));
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        logic [31:0] corners[6];
        sender_paused   = 1'b0;
        i_rst_n         = 1'b0;
        corners = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000,
                    32'hffff_ffff, 32'h0000_8000, 32'hffff_0000};
        // directed: extremes, lattice corners, sign edges
        foreach (corners[i])
            for (int j = 0; j < 4; j++)
                point_queue.push_back({corners[(i + j) % 6], corners[i]});
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int k = 0; k < 900; k++)
            point_queue.push_back({rand_coord(), rand_coord()});
        // pause the sender until the pipe has drained
        wait (point_queue.size() == 0);
        @(posedge i_clk);
        while (i_s_axis_tvalid) @(posedge i_clk);
        sender_paused = 1'b1;
        while (noise_expected.size() > 0) @(posedge i_clk);
        sender_paused = 1'b0;
        for (int k = 0; k < 926; k++)
            point_queue.push_back({rand_coord(), rand_coord()});
        wait (point_queue.size() == 0);
        @(posedge i_clk);
        while (i_s_axis_tvalid) @(posedge i_clk);
        while (noise_expected.size() > 0) @(posedge i_clk);
        repeat (LATENCY * 3) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("testbench failed");
        $finish;
    end

endmodule
`default_nettype wire
